FILE: sv/fsrd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and decode functions for the FM synth register decoder.
// No dependencies; imported by every module of the block.

package fsrd_pkg;

    localparam int NUM_OPERATORS = 36;
    localparam int NUM_VOICES    = 18;
    localparam int HALF_OPS      = 18;
    localparam int HALF_VOICES   = 9;
    localparam int OP_AW         = $clog2(NUM_OPERATORS);
    localparam int VC_AW         = $clog2(NUM_VOICES);

    localparam int REC_W  = 41;   // stored operator record
    localparam int VREC_W = 14;   // voice record
    localparam int GLB_W  = 9;    // global parameters
    localparam int PAY_W  = 45;

    localparam logic       OPC_PORT   = 1'b0;
    localparam logic       OPC_DIRECT = 1'b1;
    localparam int         PORT_DATA  = 0;
    localparam int         PORT_CHIP  = 1;
    localparam int         PORT_BCAST = 3;

    localparam logic [7:0] REG_CONN     = 8'h04;
    localparam logic [7:0] REG_KBD      = 8'h08;
    localparam logic [7:0] REG_RHY      = 8'hbd;
    localparam logic [7:0] REG_VOICE_LO = 8'ha0;
    localparam logic [7:0] REG_OP_HI    = 8'he0;
    localparam logic [4:0] OFF_LIMIT    = 5'h16;

    localparam logic [2:0] OPG_AM   = 3'h1;
    localparam logic [2:0] OPG_KSL  = 3'h2;
    localparam logic [2:0] OPG_AD   = 3'h3;
    localparam logic [2:0] OPG_SR   = 3'h4;
    localparam logic [2:0] OPG_WAVE = 3'h7;
    localparam logic [3:0] VG_FNUM  = 4'ha;
    localparam logic [3:0] VG_KEY   = 4'hb;
    localparam logic [3:0] VG_FBK   = 4'hc;

    // Bit i set where (i / 3) % 2 is one: second operator of a pair.
    localparam logic [63:0] PAIR_MASK = 64'h0000000E38E38E38;

    localparam logic [1:0] KIND_OP   = 2'd0;
    localparam logic [1:0] KIND_NOTE = 2'd1;
    localparam logic [1:0] KIND_GLB  = 2'd2;
    localparam logic [1:0] KIND_CONN = 2'd3;

    typedef enum logic [1:0] {
        MODE_OPL2 = 2'd0,
        MODE_DUAL = 2'd1,
        MODE_OPL3 = 2'd2,
        MODE_RSVD = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_CONN,
        ACT_GLB08,
        ACT_GLBBD,
        ACT_OP_AM,
        ACT_OP_KSL,
        ACT_OP_AD,
        ACT_OP_SR,
        ACT_OP_WAVE,
        ACT_V_FNUM,
        ACT_V_KEY,
        ACT_FBK
    } t_act;

    typedef enum logic [1:0] {
        S_IDLE,
        S_JOB,
        S_MOD
    } t_state;

    typedef struct packed {
        logic       opcode;
        logic [3:0] port;
        logic [8:0] address;
        logic [7:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]       kind;
        logic [5:0]       target;
        logic [PAY_W-1:0] payload;
        logic             last;
    } t_out;

    typedef struct packed {
        t_act       act;
        logic [5:0] idx;
        logic       op1_ok;
    } t_dec;

    typedef struct packed {
        logic load;
        logic rd;
        logic mod_wr;
        logic emit_direct;
        logic next_job;
        logic next_half;
    } t_cmd;

    typedef struct packed {
        logic cur_none;
        logic cur_direct;
        logic more;
        logic out_free;
        logic mod_emit;
        logic fb_second;
    } t_sts;

    // First operator of a voice on chip 0.
    function automatic logic [5:0] fb_base(input logic [3:0] vi);
        logic [5:0] b;
        unique case (vi)
            4'd0:    b = 6'd0;
            4'd1:    b = 6'd1;
            4'd2:    b = 6'd2;
            4'd3:    b = 6'd6;
            4'd4:    b = 6'd7;
            4'd5:    b = 6'd8;
            4'd6:    b = 6'd12;
            4'd7:    b = 6'd13;
            4'd8:    b = 6'd14;
            default: b = 6'd0;
        endcase
        return b;
    endfunction

    // Classify one chip register write.
    function automatic t_dec fsrd_decode(input logic c, input logic [7:0] r,
                                         input t_mode mode);
        t_dec       d;
        logic [4:0] off;
        logic [5:0] oidx;
        logic [4:0] vi;
        logic [5:0] op0;
        d.act    = ACT_NONE;
        d.idx    = '0;
        d.op1_ok = 1'b0;
        off  = r[4:0];
        oidx = 6'(off[4:3]) * 6'd6 + 6'(off[2:0]) + (c ? 6'(HALF_OPS) : 6'd0);
        vi   = 5'(r[3:0]) + (c ? 5'(HALF_VOICES) : 5'd0);
        op0  = fb_base(r[3:0]) + (c ? 6'(HALF_OPS) : 6'd0);
        priority if (r == REG_CONN && c && mode == MODE_OPL3) begin
            d.act = ACT_CONN;
        end else if (r == REG_KBD && !c) begin
            d.act = ACT_GLB08;
        end else if (r == REG_RHY && !c) begin
            d.act = ACT_GLBBD;
        end else if (r < REG_VOICE_LO || r >= REG_OP_HI) begin
            if (off < OFF_LIMIT && off[2:0] < 3'd6 && oidx < 6'(NUM_OPERATORS)) begin
                d.idx = oidx;
                unique case (r[7:5])
                    OPG_AM:   d.act = ACT_OP_AM;
                    OPG_KSL:  d.act = ACT_OP_KSL;
                    OPG_AD:   d.act = ACT_OP_AD;
                    OPG_SR:   d.act = ACT_OP_SR;
                    OPG_WAVE: d.act = ACT_OP_WAVE;
                    default:  d.act = ACT_NONE;
                endcase
            end
        end else begin
            if (r[3:0] < 4'(HALF_VOICES) && vi < 5'(NUM_VOICES)) begin
                unique case (r[7:4])
                    VG_FNUM: begin
                        d.act = ACT_V_FNUM;
                        d.idx = 6'(vi);
                    end
                    VG_KEY: begin
                        d.act = ACT_V_KEY;
                        d.idx = 6'(vi);
                    end
                    VG_FBK: begin
                        if (op0 < 6'(NUM_OPERATORS)) begin
                            d.act    = ACT_FBK;
                            d.idx    = op0;
                            d.op1_ok = (op0 + 6'd3) < 6'(NUM_OPERATORS);
                        end
                    end
                    default: d.act = ACT_NONE;
                endcase
            end
        end
        return d;
    endfunction

endpackage

FILE: sv/fsrd_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the FM synth register decoder: steps each item through its chip writes.
// Depends on fsrd_pkg; drives command signals into fsrd_dp.

module fsrd_ctrl
    import fsrd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_JOB;
                end
            end
            S_JOB: begin
                if (i_sts.cur_none || (i_sts.cur_direct && i_sts.out_free)) begin
                    n_state = i_sts.more ? S_JOB : S_IDLE;
                end else if (!i_sts.cur_direct) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (!i_sts.mod_emit || i_sts.out_free) begin
                    if (i_sts.fb_second || i_sts.more) begin
                        n_state = S_JOB;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_JOB: begin
                if (i_sts.cur_none) begin
                    o_cmd.next_job = 1'b1;
                end else if (i_sts.cur_direct) begin
                    // hold until the output register can take the item
                    o_cmd.emit_direct = i_sts.out_free;
                    o_cmd.next_job    = i_sts.out_free;
                end else begin
                    o_cmd.rd = 1'b1;
                end
            end
            S_MOD: begin
                if (!i_sts.mod_emit || i_sts.out_free) begin
                    o_cmd.mod_wr    = 1'b1;
                    o_cmd.next_half = i_sts.fb_second;
                    o_cmd.next_job  = !i_sts.fb_second;
                end
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: sv/fsrd_dp.sv
`timescale 1ns / 1ps
// Datapath of the FM synth register decoder: index latches, operator memory,
// voice and global records, output register. Depends on fsrd_pkg.

module fsrd_dp
    import fsrd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in        i_in_item,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out_item
);

    t_mode            r_mode;
    logic [7:0]       r_latch [2];
    logic [1:0]       r_job_v;
    logic             r_job_c0;
    logic [7:0]       r_job_r [2];
    logic [7:0]       r_val;
    logic             r_sel;
    logic             r_k;

    logic [REC_W-1:0] r_op_mem [NUM_OPERATORS];
    logic [NUM_OPERATORS-1:0] r_op_vld;
    logic [REC_W-1:0] r_rd_data;
    logic             r_rd_hit;

    logic [VREC_W-1:0] r_voice [NUM_VOICES];
    logic [GLB_W-1:0]  r_glb;
    t_out              r_out;
    logic              r_out_vld;

    logic [1:0]  ld_v;
    logic        ld_c0;
    logic [7:0]  ld_r0;
    logic [7:0]  ld_r1;
    logic [1:0]  ld_lat_we;
    logic        in_chip;
    logic        in_bcast;

    logic        cur_c;
    logic [7:0]  cur_r;
    t_dec        d;
    t_dec        d1;
    logic        more;
    logic        more_emit;
    logic        is_direct;
    logic        mod_emit;
    logic [5:0]  op_addr;
    logic [REC_W-1:0] rec_old;
    logic [REC_W-1:0] rec_new;
    logic        low_half;
    logic        pan_l;
    logic        pan_r;
    logic [PAY_W-1:0] pay_op;
    logic [VC_AW-1:0] vidx;
    logic [VREC_W-1:0] vrec_new;
    logic [GLB_W-1:0]  glb_new;
    t_out        dir_out;

    // Work out the chip writes an item asks for.
    always_comb begin
        in_chip   = i_in_item.port[PORT_CHIP];
        in_bcast  = i_in_item.port[PORT_BCAST];
        ld_v      = 2'b00;
        ld_c0     = 1'b0;
        ld_r0     = i_in_item.address[7:0];
        ld_r1     = i_in_item.address[7:0];
        ld_lat_we = 2'b00;
        if (r_mode != MODE_RSVD) begin
            if (i_in_item.opcode == OPC_DIRECT) begin
                unique case (r_mode)
                    MODE_OPL2: ld_v = 2'b01;
                    MODE_DUAL: ld_v = 2'b11;
                    default: begin
                        ld_v  = 2'b01;
                        ld_c0 = i_in_item.address[8];
                    end
                endcase
            end else if (i_in_item.port[PORT_DATA]) begin
                if (r_mode == MODE_OPL2) begin
                    ld_v  = 2'b01;
                    ld_r0 = r_latch[0];
                end else if (r_mode == MODE_DUAL && in_bcast) begin
                    ld_v  = 2'b11;
                    ld_r0 = r_latch[0];
                    ld_r1 = r_latch[1];
                end else begin
                    ld_v  = 2'b01;
                    ld_c0 = in_chip;
                    ld_r0 = r_latch[in_chip];
                end
            end else begin
                if (r_mode == MODE_OPL2) begin
                    ld_lat_we = 2'b01;
                end else if (r_mode == MODE_DUAL && in_bcast) begin
                    ld_lat_we = 2'b11;
                end else begin
                    ld_lat_we[in_chip] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_OPL3;
            r_latch[0] <= '0;
            r_latch[1] <= '0;
            r_job_v   <= '0;
            r_sel     <= 1'b0;
            r_k       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= t_mode'(i_cfg_wdata);
            end
            if (i_cmd.load) begin
                r_job_v <= ld_v;
                r_sel   <= 1'b0;
                r_k     <= 1'b0;
                if (ld_lat_we[0]) begin
                    r_latch[0] <= i_in_item.value;
                end
                if (ld_lat_we[1]) begin
                    r_latch[1] <= i_in_item.value;
                end
            end else if (i_cmd.next_job) begin
                r_sel <= 1'b1;
                r_k   <= 1'b0;
            end else if (i_cmd.next_half) begin
                r_k <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_job_c0   <= ld_c0;
            r_job_r[0] <= ld_r0;
            r_job_r[1] <= ld_r1;
            r_val      <= i_in_item.value;
        end
    end

    // Current chip write; the second one always goes to chip 1.
    always_comb begin
        cur_c = r_sel ? 1'b1 : r_job_c0;
        cur_r = r_sel ? r_job_r[1] : r_job_r[0];
        if (r_job_v[r_sel]) begin
            d = fsrd_decode(cur_c, cur_r, r_mode);
        end else begin
            d = '{act: ACT_NONE, idx: 6'd0, op1_ok: 1'b0};
        end
        d1        = fsrd_decode(1'b1, r_job_r[1], r_mode);
        more      = !r_sel && r_job_v[1];
        more_emit = more && (d1.act != ACT_NONE);
        is_direct = (d.act == ACT_CONN) || (d.act == ACT_GLB08) || (d.act == ACT_GLBBD)
                 || (d.act == ACT_V_FNUM) || (d.act == ACT_V_KEY);
        mod_emit  = !((d.act == ACT_FBK) && r_k);
        op_addr   = d.idx + (r_k ? 6'd3 : 6'd0);
    end

    always_comb begin
        o_sts.cur_none   = (d.act == ACT_NONE);
        o_sts.cur_direct = is_direct;
        o_sts.more       = more;
        o_sts.out_free   = !r_out_vld || i_out_ready;
        o_sts.mod_emit   = mod_emit;
        o_sts.fb_second  = (d.act == ACT_FBK) && !r_k && d.op1_ok;
    end

    // Operator memory: registered read, entries never written read as zero.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_op_mem[op_addr[OP_AW-1:0]];
            r_rd_hit  <= r_op_vld[op_addr[OP_AW-1:0]];
        end
        if (i_cmd.mod_wr) begin
            r_op_mem[op_addr[OP_AW-1:0]] <= rec_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_vld <= '0;
        end else if (i_cmd.mod_wr) begin
            r_op_vld[op_addr[OP_AW-1:0]] <= 1'b1;
        end
    end

    always_comb begin
        rec_old = r_rd_hit ? r_rd_data : '0;
        rec_new = rec_old;
        unique case (d.act)
            ACT_OP_AM:  rec_new[7:0] = r_val;
            ACT_OP_KSL: begin
                rec_new[13:8]  = ~r_val[5:0];
                rec_new[15:14] = r_val[7:6];
            end
            ACT_OP_AD: begin
                rec_new[19:16] = r_val[3:0];
                rec_new[23:20] = r_val[7:4];
            end
            ACT_OP_SR: begin
                rec_new[27:24] = r_val[3:0];
                rec_new[31:28] = r_val[7:4];
            end
            ACT_OP_WAVE: begin
                rec_new[34:32] = (r_mode == MODE_OPL3) ? r_val[2:0] : {1'b0, r_val[1:0]};
            end
            ACT_FBK: begin
                rec_new[38]    = r_val[0];
                rec_new[37:35] = r_val[3:1];
                if (r_mode == MODE_OPL3) begin
                    rec_new[39] = r_val[4];
                    rec_new[40] = r_val[5];
                end
            end
            default: rec_new = rec_old;
        endcase
    end

    // Panning outside OPL3 follows the chip the operator sits on.
    always_comb begin
        low_half = op_addr < 6'(HALF_OPS);
        unique case (r_mode)
            MODE_OPL3: begin
                pan_l = rec_new[39];
                pan_r = rec_new[40];
            end
            MODE_DUAL: begin
                pan_l = low_half;
                pan_r = !low_half;
            end
            default: begin
                pan_l = low_half;
                pan_r = low_half;
            end
        endcase
        pay_op = {3'b000, PAIR_MASK[op_addr], pan_r, pan_l, rec_new[38:0]};
    end

    always_comb begin
        vidx     = d.idx[VC_AW-1:0];
        vrec_new = r_voice[vidx];
        if (d.act == ACT_V_FNUM) begin
            vrec_new[7:0] = r_val;
        end else begin
            vrec_new[13:8] = {r_val[5], r_val[4:2], r_val[1:0]};
        end
        glb_new = r_glb;
        if (d.act == ACT_GLB08) begin
            glb_new[8] = r_val[6];
        end else begin
            glb_new[7:0] = r_val;
        end

        dir_out.last   = !more_emit;
        dir_out.target = '0;
        unique case (d.act)
            ACT_CONN: begin
                dir_out.kind    = KIND_CONN;
                dir_out.payload = PAY_W'(r_val[5:0]);
            end
            ACT_GLB08, ACT_GLBBD: begin
                dir_out.kind    = KIND_GLB;
                dir_out.payload = PAY_W'(glb_new);
            end
            default: begin
                dir_out.kind    = KIND_NOTE;
                dir_out.target  = d.idx;
                dir_out.payload = PAY_W'(vrec_new);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_VOICES; i++) begin
                r_voice[i] <= '0;
            end
            r_glb <= '0;
        end else if (i_cmd.emit_direct) begin
            if (d.act == ACT_V_FNUM || d.act == ACT_V_KEY) begin
                r_voice[vidx] <= vrec_new;
            end
            if (d.act == ACT_GLB08 || d.act == ACT_GLBBD) begin
                r_glb <= glb_new;
            end
        end
    end

    // Output register: load a new item, or drop the old one once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit_direct || (i_cmd.mod_wr && mod_emit)) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_direct) begin
            r_out <= dir_out;
        end else if (i_cmd.mod_wr && mod_emit) begin
            r_out.kind    <= KIND_OP;
            r_out.target  <= op_addr;
            r_out.payload <= pay_op;
            r_out.last    <= !more_emit;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

FILE: sv/fm_synth_register_decoder.sv
`timescale 1ns / 1ps
// FM synth register decoder, top level: sequencer plus datapath.
// Depends on fsrd_pkg, fsrd_ctrl and fsrd_dp.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one bus access per item:
//   a port access (index or data byte) or a direct register write. Output
//   channel (o_out_valid / i_out_ready) carries the commands an item causes,
//   zero to two, the final one flagged by last. i_cfg_we / i_cfg_wdata write
//   the chip mode; write it only while the block is idle.
//   Each item is taken in from the idle state, then its chip writes are worked
//   on in the job state. A connection, global or voice write is sent out from
//   the job state; an operator write reads the operator memory there and writes
//   it back in the modify state, and a feedback write does both for the two
//   operators of the pair. The operator memory is single-port, read then written.
//   Items are handled one at a time; a command waits in the output register
//   while the next chip write is worked on, and the block holds when that
//   register is still full.
//   Reset clears the index latches, all records (operator memory through
//   per-entry valid bits, at once) and sets the mode to OPL3.

module fm_synth_register_decoder
    import fsrd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out_item,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    fsrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fsrd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: tb/tb_fm_synth_register_decoder.sv
`timescale 1ns / 1ps
// Self-checking testbench for fm_synth_register_decoder: directed and random bus writes
// in every chip mode, checked against a shadow copy of the register records.
// Depends on fsrd_pkg and the fm_synth_register_decoder RTL.

module tb_fm_synth_register_decoder;
    import fsrd_pkg::*;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_in in_item = '0;
    logic out_ready = 1'b1;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_wdata = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_item;

    // shadow state of the decoder
    logic [7:0] idx_latch [2];
    logic [REC_W-1:0] op_rec [NUM_OPERATORS];
    logic [VREC_W-1:0] voice_rec [NUM_VOICES];
    logic [GLB_W-1:0] glb_rec;
    t_mode mode_now;

    t_out burst_q[$];
    t_out cmd_expected[$];
    int fail_count = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    fm_synth_register_decoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_item (o_out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #8_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void reset_shadow();
        idx_latch[0] = '0;
        idx_latch[1] = '0;
        foreach (op_rec[i]) op_rec[i] = '0;
        foreach (voice_rec[i]) voice_rec[i] = '0;
        glb_rec  = '0;
        mode_now = MODE_OPL3;
    endfunction

    function automatic void push_cmd(input logic [1:0] kind, input int target,
                                     input logic [PAY_W-1:0] payload);
        t_out c;
        c.kind    = kind;
        c.target  = 6'(target);
        c.payload = payload;
        c.last    = 1'b0;
        burst_q.push_back(c);
    endfunction

    // Stored record, with panning set by mode and chip outside OPL3, plus the pair position bit.
    function automatic logic [PAY_W-1:0] op_word(input int i);
        logic [PAY_W-1:0] w;
        w = PAY_W'(op_rec[i]);
        if (mode_now == MODE_DUAL) begin
            w[39] = (i < HALF_OPS);
            w[40] = (i >= HALF_OPS);
        end else if (mode_now != MODE_OPL3) begin
            w[39] = (i < HALF_OPS);
            w[40] = (i < HALF_OPS);
        end
        w[41] = ((i / 3) % 2) != 0;
        return w;
    endfunction

    function automatic void chip_write(input logic c, input logic [7:0] r,
                                       input logic [7:0] v);
        logic [4:0] off;
        logic [REC_W-1:0] rec;
        int idx;
        int vi;
        int op0;
        if (r == REG_CONN && c && mode_now == MODE_OPL3) begin
            push_cmd(KIND_CONN, 0, PAY_W'(v[5:0]));
        end else if (r == REG_KBD && !c) begin
            glb_rec[8] = v[6];
            push_cmd(KIND_GLB, 0, PAY_W'(glb_rec));
        end else if (r == REG_RHY && !c) begin
            glb_rec[7:0] = v;
            push_cmd(KIND_GLB, 0, PAY_W'(glb_rec));
        end else if (r < REG_VOICE_LO || r >= REG_OP_HI) begin
            off = r[4:0];
            if (off >= OFF_LIMIT || off[2:0] >= 3'd6) return;
            idx = off[4:3] * 6 + off[2:0] + (c ? HALF_OPS : 0);
            if (idx >= NUM_OPERATORS) return;
            rec = op_rec[idx];
            case (r[7:5])
                OPG_AM: rec[7:0] = v;
                OPG_KSL: begin
                    rec[13:8]  = ~v[5:0];
                    rec[15:14] = v[7:6];
                end
                OPG_AD: rec[23:16] = v;
                OPG_SR: rec[31:24] = v;
                OPG_WAVE: rec[34:32] = (mode_now == MODE_OPL3) ? v[2:0] : {1'b0, v[1:0]};
                default: return;
            endcase
            op_rec[idx] = rec;
            push_cmd(KIND_OP, idx, op_word(idx));
        end else begin
            if (r[3:0] >= HALF_VOICES) return;
            vi = r[3:0] + (c ? HALF_VOICES : 0);
            if (vi >= NUM_VOICES) return;
            case (r[7:4])
                VG_FNUM: begin
                    voice_rec[vi][7:0] = v;
                    push_cmd(KIND_NOTE, vi, PAY_W'(voice_rec[vi]));
                end
                VG_KEY: begin
                    voice_rec[vi][9:8]   = v[1:0];
                    voice_rec[vi][12:10] = v[4:2];
                    voice_rec[vi][13]    = v[5];
                    push_cmd(KIND_NOTE, vi, PAY_W'(voice_rec[vi]));
                end
                VG_FBK: begin
                    // update both operators of the pair, report the first only
                    op0 = (vi / 3) * 6 + vi % 3;
                    for (int k = 0; k < 2; k++) begin
                        if (op0 + 3 * k < NUM_OPERATORS) begin
                            op_rec[op0 + 3 * k][38]    = v[0];
                            op_rec[op0 + 3 * k][37:35] = v[3:1];
                            if (mode_now == MODE_OPL3) begin
                                op_rec[op0 + 3 * k][39] = v[4];
                                op_rec[op0 + 3 * k][40] = v[5];
                            end
                        end
                    end
                    if (op0 < NUM_OPERATORS) push_cmd(KIND_OP, op0, op_word(op0));
                end
                default: ;
            endcase
        end
    endfunction

    function automatic void model_access(input t_in it);
        logic chip;
        logic both;
        chip = it.port[PORT_CHIP];
        both = it.port[PORT_BCAST];
        burst_q.delete();
        if (mode_now == MODE_RSVD) return;
        if (it.opcode == OPC_PORT) begin
            if (it.port[PORT_DATA]) begin
                if (mode_now == MODE_OPL2) begin
                    chip_write(1'b0, idx_latch[0], it.value);
                end else if (mode_now == MODE_DUAL && both) begin
                    chip_write(1'b0, idx_latch[0], it.value);
                    chip_write(1'b1, idx_latch[1], it.value);
                end else begin
                    chip_write(chip, idx_latch[chip], it.value);
                end
            end else begin
                if (mode_now == MODE_OPL2) begin
                    idx_latch[0] = it.value;
                end else if (mode_now == MODE_DUAL && both) begin
                    idx_latch[0] = it.value;
                    idx_latch[1] = it.value;
                end else begin
                    idx_latch[chip] = it.value;
                end
            end
        end else begin
            if (mode_now == MODE_OPL2) begin
                chip_write(1'b0, it.address[7:0], it.value);
            end else if (mode_now == MODE_DUAL) begin
                chip_write(1'b0, it.address[7:0], it.value);
                chip_write(1'b1, it.address[7:0], it.value);
            end else begin
                chip_write(it.address[8], it.address[7:0], it.value);
            end
        end
        if (burst_q.size() > 0) burst_q[burst_q.size() - 1].last = 1'b1;
        foreach (burst_q[i]) cmd_expected.push_back(burst_q[i]);
    endfunction

    function automatic t_in direct_write(input logic c, input logic [7:0] r,
                                         input logic [7:0] v);
        t_in it;
        it.opcode  = OPC_DIRECT;
        it.port    = 4'($urandom);
        it.address = {c, r};
        it.value   = v;
        return it;
    endfunction

    function automatic t_in port_access(input logic [3:0] p, input logic [7:0] v);
        t_in it;
        it.opcode  = OPC_PORT;
        it.port    = p;
        it.address = 9'($urandom);
        it.value   = v;
        return it;
    endfunction

    // Mostly registers that decode to something, the rest anything.
    function automatic logic [7:0] pick_register();
        logic [2:0] grp;
        logic [4:0] off;
        logic [3:0] vg;
        logic [3:0] vi;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                case ($urandom_range(0, 4))
                    0: grp = OPG_AM;
                    1: grp = OPG_KSL;
                    2: grp = OPG_AD;
                    3: grp = OPG_SR;
                    default: grp = OPG_WAVE;
                endcase
                if ($urandom_range(0, 7) == 0) off = 5'($urandom);
                else off = 5'($urandom_range(0, 2) * 8 + $urandom_range(0, 5));
                return {grp, off};
            end
            5, 6, 7: begin
                case ($urandom_range(0, 2))
                    0: vg = VG_FNUM;
                    1: vg = VG_KEY;
                    default: vg = VG_FBK;
                endcase
                if ($urandom_range(0, 7) == 0) vi = 4'($urandom);
                else vi = 4'($urandom_range(0, 8));
                return {vg, vi};
            end
            8: begin
                case ($urandom_range(0, 2))
                    0: return REG_CONN;
                    1: return REG_KBD;
                    default: return REG_RHY;
                endcase
            end
            default: return 8'($urandom);
        endcase
    endfunction

    // Hold valid across back-to-back items; drop it only for a gap.
    task automatic put_access(input t_in it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        model_access(it);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (cmd_expected.size() != 0) @(posedge i_clk);
        // an item with no command may still be in flight
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_mode(input t_mode m);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        mode_now = m;
    endtask

    function automatic bit field_ok(input string name, input logic [PAY_W-1:0] want,
                                    input logic [PAY_W-1:0] got);
        if (want === got) return 1'b1;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : check_cmd
        t_out want;
        bit ok;
        if (rst_n && o_out_valid && out_ready) begin
            if (cmd_expected.size() == 0) begin
                $display("%0t: unexpected command, expected none, actual kind %0d target %0d",
                         $time, o_out_item.kind, o_out_item.target);
                fail_count++;
            end else begin
                want = cmd_expected.pop_front();
                ok = field_ok("kind", PAY_W'(want.kind), PAY_W'(o_out_item.kind));
                ok = field_ok("target", PAY_W'(want.target), PAY_W'(o_out_item.target)) && ok;
                ok = field_ok("payload", want.payload, o_out_item.payload) && ok;
                ok = field_ok("last", PAY_W'(want.last), PAY_W'(o_out_item.last)) && ok;
                if (!ok) fail_count++;
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 20) begin
            stall_left = pick_gap();
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic test_operator_groups();
        put_access(direct_write(1'b0, {OPG_AM, 5'h00}, 8'hff));
        put_access(direct_write(1'b1, {OPG_AM, 5'h15}, 8'h00));   // last operator of chip 1
        put_access(direct_write(1'b0, {OPG_KSL, 5'h00}, 8'h00));  // volume inverts to all ones
        put_access(direct_write(1'b0, {OPG_AD, 5'h08}, 8'ha5));
        put_access(direct_write(1'b1, {OPG_SR, 5'h11}, 8'h5a));
        put_access(direct_write(1'b0, {OPG_WAVE, 5'h02}, 8'hff));
        // unused offsets and group zero: nothing comes out
        put_access(direct_write(1'b0, {OPG_AM, 5'h06}, 8'h12));
        put_access(direct_write(1'b0, {OPG_KSL, 5'h0f}, 8'h34));
        put_access(direct_write(1'b1, {OPG_AM, 5'h16}, 8'h56));
        put_access(direct_write(1'b0, {3'b000, 5'h01}, 8'h78));
    endtask

    task automatic test_voice_and_feedback();
        put_access(direct_write(1'b0, {VG_FNUM, 4'd0}, 8'hff));
        put_access(direct_write(1'b0, {VG_KEY, 4'd8}, 8'hff));
        put_access(direct_write(1'b1, {VG_KEY, 4'd9}, 8'h55));    // voice offset out of range
        put_access(direct_write(1'b0, {VG_FBK, 4'd0}, 8'hff));
        put_access(direct_write(1'b1, {VG_FBK, 4'd8}, 8'h3e));
    endtask

    task automatic test_globals_and_connection();
        put_access(direct_write(1'b1, REG_CONN, 8'hff));
        put_access(direct_write(1'b0, REG_CONN, 8'h3f));
        put_access(direct_write(1'b0, REG_KBD, 8'h40));
        put_access(direct_write(1'b0, REG_RHY, 8'hff));
        put_access(direct_write(1'b1, REG_RHY, 8'h55));
        put_access(direct_write(1'b1, REG_KBD, 8'hff));
    endtask

    task automatic test_port_routing();
        put_access(port_access(4'b0010, {OPG_KSL, 5'h05}));       // index, chip 1
        put_access(port_access(4'b0011, 8'h80));
        set_mode(MODE_OPL2);
        put_access(port_access(4'b1110, {OPG_WAVE, 5'h03}));      // chip bits ignored
        put_access(port_access(4'b1111, 8'hff));
        put_access(direct_write(1'b1, {VG_FBK, 4'd0}, 8'h31));    // address bit 8 ignored
        set_mode(MODE_DUAL);
        put_access(port_access(4'b1000, {VG_KEY, 4'd2}));         // broadcast index
        put_access(port_access(4'b1001, 8'h2d));
        put_access(direct_write(1'b0, {OPG_WAVE, 5'h05}, 8'h07));
    endtask

    task automatic test_reserved_mode();
        set_mode(MODE_RSVD);
        put_access(direct_write(1'b0, REG_RHY, 8'hff));
        put_access(direct_write(1'b1, REG_CONN, 8'h3f));
        put_access(port_access(4'b0000, {OPG_AM, 5'h00}));
        put_access(port_access(4'b0001, 8'hff));
        for (int i = 0; i < 20; i++) begin
            put_access(direct_write(1'($urandom), pick_register(), 8'($urandom)));
        end
    endtask

    task automatic test_random_traffic(input t_mode m, input int n_items);
        int sent;
        logic [3:0] sel;
        set_mode(m);
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 39) == 0) calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    put_access(direct_write(1'($urandom), pick_register(), 8'($urandom)));
                    sent++;
                end
                5, 6, 7, 8: begin
                    sel = 4'($urandom);
                    sel[PORT_DATA] = 1'b0;
                    put_access(port_access(sel, pick_register()));
                    sel[PORT_DATA] = 1'b1;
                    put_access(port_access(sel, 8'($urandom)));
                    sent += 2;
                end
                default: begin
                    // stray index or data byte on any port
                    put_access(port_access(4'($urandom), 8'($urandom)));
                    sent++;
                end
            endcase
        end
        calm = 1'b0;
    endtask

    initial begin
        reset_shadow();
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_operator_groups();
        test_voice_and_feedback();
        test_globals_and_connection();
        test_port_routing();
        test_reserved_mode();
        test_random_traffic(MODE_OPL3, 220);
        test_random_traffic(MODE_OPL2, 200);
        test_random_traffic(MODE_DUAL, 200);
        test_random_traffic(MODE_OPL3, 200);
        test_random_traffic(MODE_DUAL, 200);
        test_random_traffic(MODE_OPL2, 200);
        test_random_traffic(MODE_OPL3, 180);
        wait_idle();
        if (fail_count == 0 && cmd_expected.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
